@@ rtl/tq_pkg.sv @@
// ----------------------------------------------------------------------------
// tq_pkg
// Shared constants, result codes and controller/datapath interface types for
// the team queue.
// ----------------------------------------------------------------------------
package tq_pkg;

  localparam int unsigned DEF_CAPACITY     = 256;
  localparam int unsigned DEF_TEAMS        = 16;
  localparam int unsigned DEF_ELEMENT_BITS = 20;

  localparam int unsigned ELEM_FIELD_W   = 20;
  localparam int unsigned TEAM_FIELD_W   = 4;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned TEAM_CODES     = 1 << TEAM_FIELD_W;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic    CMD_ENQ = 1'b0;
  localparam logic    CMD_DEQ = 1'b1;

  localparam status_t ST_ENQUEUED = 2'd0;
  localparam status_t ST_DEQUEUED = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  typedef struct packed {
    logic accept;
    logic rd_team;
    logic rd_slot;
    logic commit_enq;
    logic commit_deq;
    logic commit_flag;
  } dp_cmd_t;

  typedef struct packed {
    logic init_done;
    logic empty;
    logic full;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/tq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tq_ctrl
// Sequencer for the team queue: takes one item at a time and steps the
// datapath through its memory reads and the final commit.
// ----------------------------------------------------------------------------
module tq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  input  tq_pkg::dp_status_t  sts,
  output tq_pkg::dp_cmd_t     cmd
);
  import tq_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ENQ  = 3'd2;
  localparam logic [2:0] S_FLAG = 3'd3;
  localparam logic [2:0] S_DQ_T = 3'd4;
  localparam logic [2:0] S_DQ_S = 3'd5;
  localparam logic [2:0] S_DQ_C = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_DEQ) begin
            state_nxt = sts.empty ? S_FLAG : S_DQ_T;
          end else begin
            state_nxt = sts.full ? S_FLAG : S_ENQ;
          end
        end
      end
      S_ENQ: begin
        if (sts.out_free) begin
          cmd.commit_enq = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FLAG: begin
        if (sts.out_free) begin
          cmd.commit_flag = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DQ_T: begin
        cmd.rd_team = 1'b1;
        state_nxt   = S_DQ_S;
      end
      S_DQ_S: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = S_DQ_C;
      end
      S_DQ_C: begin
        if (sts.out_free) begin
          cmd.commit_deq = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ rtl/tq_dpath.sv @@
// ----------------------------------------------------------------------------
// tq_dpath
// Team queue datapath: slot store, link memory, free ring, per-team head,
// tail and active tables, team order ring, counters and result register.
// ----------------------------------------------------------------------------
module tq_dpath #(
  parameter int unsigned CAPACITY     = tq_pkg::DEF_CAPACITY,
  parameter int unsigned TEAMS        = tq_pkg::DEF_TEAMS,
  parameter int unsigned ELEMENT_BITS = tq_pkg::DEF_ELEMENT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tq_pkg::dp_cmd_t                   cmd,
  output tq_pkg::dp_status_t                sts,
  input  logic                              in_command,
  input  logic [tq_pkg::ELEM_FIELD_W-1:0]   in_element,
  input  logic [tq_pkg::TEAM_FIELD_W-1:0]   in_team,
  input  logic                              out_stall,
  output logic                              out_valid,
  output tq_pkg::status_t                   out_status,
  output logic [tq_pkg::ELEM_FIELD_W-1:0]   out_dequeued_element,
  output logic [tq_pkg::TEAM_FIELD_W-1:0]   out_dequeued_team
);
  import tq_pkg::*;

  localparam int unsigned EW     = ELEMENT_BITS;
  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned TEAM_W = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int unsigned OCNT_W = (TEAMS > 1) ? $clog2(TEAMS + 1) : 1;
  localparam int unsigned EXW    = (EW > ELEM_FIELD_W) ? EW : ELEM_FIELD_W;
  localparam int unsigned TXW    = (TEAM_W > TEAM_FIELD_W) ? TEAM_W : TEAM_FIELD_W;

  // storage
  logic [EW-1:0]     elem_mem   [CAPACITY];
  logic [SLOT_W-1:0] next_mem   [CAPACITY];
  logic [SLOT_W-1:0] free_mem   [CAPACITY];
  logic [SLOT_W-1:0] head_mem   [TEAMS];
  logic [SLOT_W-1:0] tail_mem   [TEAMS];
  logic              active_mem [TEAMS];
  logic [TEAM_W-1:0] order_mem  [TEAMS];

  // team number folding table
  logic [TEAM_W-1:0] team_map [TEAM_CODES];
  for (genvar g = 0; g < TEAM_CODES; g++) begin : g_team_map
    localparam int unsigned FOLD = g % TEAMS;
    assign team_map[g] = TEAM_W'(FOLD);
  end

  // control state
  logic [SLOT_W-1:0] free_head_r;
  logic [CNT_W-1:0]  free_count_r;
  logic [CNT_W-1:0]  fill_r;
  logic [TEAM_W-1:0] order_head_r;
  logic [OCNT_W-1:0] order_count_r;
  logic              clr_busy_r;
  logic [TEAM_W-1:0] clr_idx_r;
  logic              out_valid_r;

  // item and read data
  logic [TEAM_W-1:0] team_q_r;
  logic [EW-1:0]     elem_q_r;
  status_t           flag_st_r;
  logic              fr_init_r;
  logic [SLOT_W-1:0] fr_idx_r;
  logic [SLOT_W-1:0] fr_rd_r;
  logic              act_rd_r;
  logic [SLOT_W-1:0] tail_rd_r;
  logic [SLOT_W-1:0] head_rd_r;
  logic [TEAM_W-1:0] ord_rd_r;
  logic              last_r;
  logic [EW-1:0]     elem_rd_r;
  logic [SLOT_W-1:0] next_rd_r;
  status_t           out_status_r;
  logic [EW-1:0]     out_elem_r;
  logic [TEAM_W-1:0] out_team_r;

  logic [TEAM_W-1:0] team_in;
  logic [EXW-1:0]    elem_in_ext;
  logic [EXW-1:0]    elem_out_ext;
  logic [TXW-1:0]    team_out_ext;
  logic [SLOT_W-1:0] slot_enq;
  logic [CNT_W:0]    free_sum;
  logic [SLOT_W-1:0] free_tail;
  logic [OCNT_W:0]   order_sum;
  logic [TEAM_W-1:0] order_tail;
  logic              order_room;
  logic              free_room;
  logic              new_team;
  logic [TEAM_W-1:0] tail_ra;
  logic              head_we;
  logic [TEAM_W-1:0] head_wa;
  logic [SLOT_W-1:0] head_wd;
  logic              act_we;
  logic [TEAM_W-1:0] act_wa;
  logic              act_wd;

  assign team_in     = team_map[in_team];
  assign elem_in_ext = EXW'(in_element);
  assign slot_enq    = fr_init_r ? fr_idx_r : fr_rd_r;
  assign new_team    = !act_rd_r;

  assign free_sum  = (CNT_W+1)'(free_head_r) + (CNT_W+1)'(free_count_r);
  assign free_tail = (free_sum >= (CNT_W+1)'(CAPACITY)) ?
                     SLOT_W'(free_sum - (CNT_W+1)'(CAPACITY)) : SLOT_W'(free_sum);
  assign order_sum  = (OCNT_W+1)'(order_head_r) + (OCNT_W+1)'(order_count_r);
  assign order_tail = (order_sum >= (OCNT_W+1)'(TEAMS)) ?
                      TEAM_W'(order_sum - (OCNT_W+1)'(TEAMS)) : TEAM_W'(order_sum);
  assign order_room = (order_count_r < OCNT_W'(TEAMS));
  assign free_room  = (free_count_r < CNT_W'(CAPACITY));

  assign tail_ra = cmd.accept ? team_in : ord_rd_r;

  assign head_we = (cmd.commit_enq && new_team) || (cmd.commit_deq && !last_r);
  assign head_wa = cmd.commit_enq ? team_q_r : ord_rd_r;
  assign head_wd = cmd.commit_enq ? slot_enq : next_rd_r;

  assign act_we = clr_busy_r || (cmd.commit_enq && new_team) || (cmd.commit_deq && last_r);
  assign act_wa = clr_busy_r ? clr_idx_r : (cmd.commit_enq ? team_q_r : ord_rd_r);
  assign act_wd = !clr_busy_r && cmd.commit_enq;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.commit_enq) elem_mem[slot_enq] <= elem_q_r;
    if (cmd.rd_slot) elem_rd_r <= elem_mem[head_rd_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_enq && act_rd_r) next_mem[tail_rd_r] <= slot_enq;
    if (cmd.rd_slot) next_rd_r <= next_mem[head_rd_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_deq && free_room) free_mem[free_tail] <= head_rd_r;
    if (cmd.accept) fr_rd_r <= free_mem[free_head_r];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd.rd_team) head_rd_r <= head_mem[ord_rd_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_enq) tail_mem[team_q_r] <= slot_enq;
    if (cmd.accept || cmd.rd_team) tail_rd_r <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (act_we) active_mem[act_wa] <= act_wd;
    if (cmd.accept) act_rd_r <= active_mem[team_in];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_enq && new_team && order_room) order_mem[order_tail] <= team_q_r;
    if (cmd.accept) ord_rd_r <= order_mem[order_head_r];
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      team_q_r  <= team_in;
      elem_q_r  <= elem_in_ext[EW-1:0];
      flag_st_r <= (in_command == CMD_DEQ) ? ST_EMPTY : ST_FULL;
      fr_init_r <= (CNT_W'(free_head_r) >= fill_r);
      fr_idx_r  <= free_head_r;
    end
    if (cmd.rd_slot) begin
      last_r <= (head_rd_r == tail_rd_r);
    end
    if (cmd.commit_enq) begin
      out_status_r <= ST_ENQUEUED;
      out_elem_r   <= '0;
      out_team_r   <= '0;
    end else if (cmd.commit_deq) begin
      out_status_r <= ST_DEQUEUED;
      out_elem_r   <= elem_rd_r;
      out_team_r   <= ord_rd_r;
    end else if (cmd.commit_flag) begin
      out_status_r <= flag_st_r;
      out_elem_r   <= '0;
      out_team_r   <= '0;
    end
  end

  // counters and handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r   <= '0;
      free_count_r  <= CNT_W'(CAPACITY);
      fill_r        <= '0;
      order_head_r  <= '0;
      order_count_r <= '0;
      clr_busy_r    <= 1'b1;
      clr_idx_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_idx_r == TEAM_W'(TEAMS - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
      end
      if (cmd.commit_enq) begin
        free_head_r  <= (free_head_r == SLOT_W'(CAPACITY - 1)) ? '0 : free_head_r + 1'b1;
        free_count_r <= free_count_r - 1'b1;
        if (new_team && order_room) begin
          order_count_r <= order_count_r + 1'b1;
        end
      end
      if (cmd.commit_deq) begin
        if (last_r) begin
          order_head_r  <= (order_head_r == TEAM_W'(TEAMS - 1)) ? '0 : order_head_r + 1'b1;
          order_count_r <= order_count_r - 1'b1;
        end
        if (free_room) begin
          free_count_r <= free_count_r + 1'b1;
        end
        if (fill_r != CNT_W'(CAPACITY)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.commit_enq || cmd.commit_deq || cmd.commit_flag) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.init_done = !clr_busy_r;
  assign sts.empty     = (order_count_r == '0);
  assign sts.full      = (free_count_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign elem_out_ext = EXW'(out_elem_r);
  assign team_out_ext = TXW'(out_team_r);

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_dequeued_element = elem_out_ext[ELEM_FIELD_W-1:0];
  assign out_dequeued_team    = team_out_ext[TEAM_FIELD_W-1:0];

endmodule

@@ rtl/team_queue.sv @@
// ----------------------------------------------------------------------------
// team_queue
// Grouped FIFO: elements queue behind others of their team, teams are served
// in order of arrival, one result item per input item.
// ----------------------------------------------------------------------------
// One item is worked on at a time and each gives exactly one result item.
// An enqueue reads the free slot, team tail and team active flag, then links
// and writes. A dequeue walks a chain of synchronous memory reads: team order
// ring, then the team's head and tail, then the slot's element and link, then
// the commit. A dequeue on an empty queue or an enqueue on a full store goes
// from acceptance straight to its commit. A result may wait on the output
// while the next item is taken; the commit of that item waits until the
// output register is free. After reset the team active table is cleared
// entry by entry and in_stall stays high until the clearing is done.
module team_queue #(
  parameter int unsigned CAPACITY     = tq_pkg::DEF_CAPACITY,
  parameter int unsigned TEAMS        = tq_pkg::DEF_TEAMS,
  parameter int unsigned ELEMENT_BITS = tq_pkg::DEF_ELEMENT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [tq_pkg::ELEM_FIELD_W-1:0]   in_element,
  input  logic [tq_pkg::TEAM_FIELD_W-1:0]   in_team,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tq_pkg::STATUS_W-1:0]       out_status,
  output logic [tq_pkg::ELEM_FIELD_W-1:0]   out_dequeued_element,
  output logic [tq_pkg::TEAM_FIELD_W-1:0]   out_dequeued_team
);
  import tq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  tq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  tq_dpath #(
    .CAPACITY     (CAPACITY),
    .TEAMS        (TEAMS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_command           (in_command),
    .in_element           (in_element),
    .in_team              (in_team),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_dequeued_element (out_dequeued_element),
    .out_dequeued_team    (out_dequeued_team)
  );

endmodule

@@ rtl/tq_checker.sv @@
// ----------------------------------------------------------------------------
// tq_checker
// Port-level checks for the team queue, bound to the top level.
// ----------------------------------------------------------------------------
module tq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_command,
  input logic [tq_pkg::ELEM_FIELD_W-1:0]   in_element,
  input logic [tq_pkg::TEAM_FIELD_W-1:0]   in_team,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [tq_pkg::STATUS_W-1:0]       out_status,
  input logic [tq_pkg::ELEM_FIELD_W-1:0]   out_dequeued_element,
  input logic [tq_pkg::TEAM_FIELD_W-1:0]   out_dequeued_team
);
  import tq_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result item present after reset");

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result item dropped");

  // a waiting input item holds still
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable({in_command, in_element, in_team}))
    else $error("stalled input item changed");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is at work");

  // only a dequeue carries an element and team
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DEQUEUED) |->
      (out_dequeued_element == '0) && (out_dequeued_team == '0))
    else $error("non-dequeue result carries payload");

endmodule

bind team_queue tq_checker u_tq_checker (.*);

@@ bench/tb_team_queue.sv @@
// ----------------------------------------------------------------------------
// tb_team_queue
// Self-checking bench for the grouped FIFO. A mirror of the team lists, the
// team order and the free slot ring predicts the status, element and team of
// every result; each result is checked against the oldest prediction. Runs
// directed corner cases, a fill past full and a drain past empty, random
// team mixes with idling on both sides, and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb_team_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import tq_pkg::*;

  localparam int SLOTS        = DEF_CAPACITY;
  localparam int GROUPS       = DEF_TEAMS;
  localparam int SLOT_W       = $clog2(DEF_CAPACITY);
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  typedef logic [ELEM_FIELD_W-1:0] elem_t;
  typedef logic [TEAM_FIELD_W-1:0] team_t;
  typedef logic [SLOT_W-1:0]       slot_t;

  typedef struct packed {
    status_t status;
    elem_t   element;
    team_t   team;
  } outcome_t;

  logic    clk        = 1'b0;
  logic    rst_n      = 1'b0;
  logic    in_valid   = 1'b0;
  logic    in_command = CMD_ENQ;
  elem_t   in_element = '0;
  team_t   in_team    = '0;
  logic    out_stall  = 1'b0;
  logic    in_stall;
  logic    out_valid;
  status_t out_status;
  elem_t   out_dequeued_element;
  team_t   out_dequeued_team;

  team_queue DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_element           (in_element),
    .in_team              (in_team),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_dequeued_element (out_dequeued_element),
    .out_dequeued_team    (out_dequeued_team)
  );

  // mirror of the queue
  elem_t       slot_value [SLOTS];
  slot_t       slot_link  [SLOTS];
  slot_t       free_slots [SLOTS];
  int unsigned free_rd;
  int unsigned free_cnt;
  slot_t       first_slot [GROUPS];
  slot_t       last_slot  [GROUPS];
  bit          team_waiting [GROUPS];
  team_t       team_order [GROUPS];
  int unsigned order_rd;
  int unsigned order_cnt;

  outcome_t expected_outcomes [$];
  int       status_tally [4];
  int       results_checked;
  int       mismatches;
  int       quiet_cycles;
  int       stall_left;
  bit       idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic outcome_t queue_outcome(logic cmd, elem_t elem, team_t tm);
    outcome_t    res;
    slot_t       slot;
    int unsigned t;
    res = '{ST_ENQUEUED, elem_t'(0), team_t'(0)};
    if (cmd == CMD_ENQ) begin
      t = tm % GROUPS;
      if (free_cnt == 0) begin
        res.status = ST_FULL;
      end else begin
        slot = free_slots[free_rd];
        free_rd = (free_rd + 1) % SLOTS;
        free_cnt--;
        slot_value[slot] = elem;
        slot_link[slot] = '0;
        if (team_waiting[t]) begin
          slot_link[last_slot[t]] = slot;
          last_slot[t] = slot;
        end else begin
          team_waiting[t] = 1'b1;
          first_slot[t] = slot;
          last_slot[t] = slot;
          team_order[(order_rd + order_cnt) % GROUPS] = team_t'(t);
          order_cnt++;
        end
      end
    end else if (order_cnt == 0) begin
      res.status = ST_EMPTY;
    end else begin
      t = team_order[order_rd];
      slot = first_slot[t];
      res = '{ST_DEQUEUED, slot_value[slot], team_t'(t)};
      if (slot == last_slot[t]) begin
        team_waiting[t] = 1'b0;
        order_rd = (order_rd + 1) % GROUPS;
        order_cnt--;
      end else begin
        first_slot[t] = slot_link[slot];
      end
      free_slots[(free_rd + free_cnt) % SLOTS] = slot;
      free_cnt++;
    end
    return res;
  endfunction

  task automatic send_item(logic cmd, elem_t elem, team_t tm);
    outcome_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_element <= elem;
    in_team    <= tm;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = queue_outcome(cmd, elem, tm);
    expected_outcomes = {expected_outcomes, res};
    status_tally[res.status]++;
  endtask

  task automatic test_directed();
    send_item(CMD_DEQ, '1, '1);
    send_item(CMD_ENQ, '0, '0);
    send_item(CMD_ENQ, '1, '1);
    send_item(CMD_ENQ, 20'h5A5A5, 4'd0);
    send_item(CMD_ENQ, 20'hA5A5A, 4'd7);
    send_item(CMD_ENQ, 20'h00001, 4'd15);
    repeat (5) send_item(CMD_DEQ, '0, '0);
    send_item(CMD_DEQ, '1, '0);
    // retired team comes back behind a newer one
    send_item(CMD_ENQ, 20'h80000, 4'd8);
    send_item(CMD_ENQ, 20'h7FFFF, 4'd3);
    send_item(CMD_DEQ, '0, '1);
    send_item(CMD_ENQ, 20'h00010, 4'd8);
    send_item(CMD_ENQ, 20'h00020, 4'd3);
    repeat (4) send_item(CMD_DEQ, '0, '0);
  endtask

  task automatic test_fill_and_drain();
    repeat (SLOTS + 2) send_item(CMD_ENQ, elem_t'($urandom), team_t'($urandom));
    repeat (SLOTS + 2) send_item(CMD_DEQ, elem_t'($urandom), team_t'($urandom));
  endtask

  task automatic test_team_mix(int items);
    int sent;
    int run_len;
    int enq_pct;
    int base;
    int span;
    sent = 0;
    while (sent < items) begin
      run_len = $urandom_range(10, 40);
      enq_pct = $urandom_range(40, 70);
      base    = $urandom_range(0, GROUPS - 1);
      span    = ($urandom_range(0, 3) == 0) ? GROUPS : $urandom_range(1, 4);
      repeat (run_len) begin
        if ($urandom_range(1, 100) <= enq_pct)
          send_item(CMD_ENQ, elem_t'($urandom),
                    team_t'((base + $urandom_range(0, span - 1)) % GROUPS));
        else
          send_item(CMD_DEQ, elem_t'($urandom), team_t'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_steady_stream(int items);
    idle_on = 1'b0;
    repeat (items)
      send_item(logic'($urandom_range(0, 1)), elem_t'($urandom), team_t'($urandom));
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = '{out_status, out_dequeued_element, out_dequeued_team};
      results_checked++;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: status %0d element %h team %0d",
                   got.status, got.element, got.team);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.team !== want.team) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: expected %0d/%h/%0d, got %0d/%h/%0d (status/element/team)",
                     want.status, want.element, want.team,
                     got.status, got.element, got.team);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++)
      free_slots[i] = slot_t'(i);
    for (int i = 0; i < GROUPS; i++)
      team_waiting[i] = 1'b0;
    free_rd   = 0;
    free_cnt  = SLOTS;
    order_rd  = 0;
    order_cnt = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_team_mix(400);
    test_steady_stream(200);

    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("items: %0d enqueued, %0d dequeued, %0d dequeues on empty, %0d drops on full",
             status_tally[ST_ENQUEUED], status_tally[ST_DEQUEUED],
             status_tally[ST_EMPTY], status_tally[ST_FULL]);
    $display("results checked: %0d, mismatches: %0d", results_checked, mismatches);
    if (mismatches == 0 && expected_outcomes.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tq_pkg.sv
rtl/tq_ctrl.sv
rtl/tq_dpath.sv
rtl/team_queue.sv
rtl/tq_checker.sv
bench/tb_team_queue.sv
